### rtl/core/lzv_pkg.sv
// Package for the LEB128 / zigzag varint decoder.
// Holds shared widths, status and register codes, the result struct and the zigzag function.
// No dependencies.
package lzv_pkg;

    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned SHIFT_W  = 6;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned APB_DW   = 32;

    localparam logic [6:0]          GROUP_MASK = 7'h7f;
    localparam int unsigned         CONT_BIT   = 7;
    localparam int unsigned         SIGN_BIT   = 6;
    localparam logic [COUNT_W-1:0]  MAX_BYTES  = 4'd10;
    localparam logic [SHIFT_W-1:0]  GROUP_BITS = 6'd7;

    // Register word index 0 holds the decode mode.
    localparam logic [APB_AW-1:2]   REG_DECODE_MODE = 1'b0;
    localparam logic [MODE_W-1:0]   MODE_RESET      = 2'd1;
    // Bit 1 of the mode selects the unsigned form with zigzag, bit 0 adds zigzag to signed.
    localparam int unsigned         MODE_UNSIGNED_BIT = 1;
    localparam int unsigned         MODE_ZIGZAG_BIT   = 0;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TRUNC    = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] byte_count;
        t_status            status;
    } t_result;

    function automatic logic [VALUE_W-1:0] zigzag(input logic [VALUE_W-1:0] n);
        return (n >> 1) ^ {VALUE_W{n[0]}};
    endfunction

endpackage

### rtl/core/lzv_cfg.sv
// APB-style configuration register for the varint decoder (decode mode).
// Depends on lzv_pkg.
module lzv_cfg
    import lzv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [MODE_W-1:0] o_mode
);

    logic [MODE_W-1:0] r_mode;
    logic              w_hit;

    assign w_hit  = (paddr[APB_AW-1:2] == REG_DECODE_MODE);
    assign pready = 1'b1;
    assign o_mode = r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
        end else if (psel && penable && pwrite && pready && w_hit) begin
            r_mode <= pwdata[MODE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_hit) begin
            prdata = {{(APB_DW-MODE_W){1'b0}}, r_mode};
        end
    end

endmodule

### rtl/core/lzv_dec.sv
// Decode stage: holds the accumulator state and turns one registered byte into a
// state update and, when the value or the buffer ends or it overflows, a result. Depends on lzv_pkg.
module lzv_dec
    import lzv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  logic [MODE_W-1:0] i_mode,
    output logic              o_emit,
    output t_result           o_res
);

    logic [VALUE_W-1:0] r_acc;
    logic [SHIFT_W-1:0] r_bit_shift;
    logic [COUNT_W-1:0] r_bytes_seen;

    logic [VALUE_W-1:0] w_acc;
    logic [COUNT_W-1:0] w_count;
    logic [6:0]         w_end_shift;
    logic [VALUE_W-1:0] w_signed;
    logic [VALUE_W-1:0] w_value;
    logic               w_cont;
    logic               w_overflow;

    assign w_acc       = r_acc | ({{(VALUE_W-7){1'b0}}, i_byte[6:0] & GROUP_MASK} << r_bit_shift);
    assign w_count     = r_bytes_seen + 1'b1;
    // Seven bits per byte: 8*count - count.
    assign w_end_shift = {w_count, 3'b000} - {3'b000, w_count};
    assign w_cont      = i_byte[CONT_BIT];
    assign w_overflow  = w_cont && (w_count >= MAX_BYTES);

    always_comb begin
        w_signed = w_acc;
        // A ten-byte value fills all 64 bits and is never sign-extended.
        if (!w_end_shift[6] && i_byte[SIGN_BIT]) begin
            w_signed = w_acc | ({VALUE_W{1'b1}} << w_end_shift[5:0]);
        end
        if (i_mode[MODE_UNSIGNED_BIT]) begin
            w_value = zigzag(w_acc);
        end else if (i_mode[MODE_ZIGZAG_BIT]) begin
            w_value = zigzag(w_signed);
        end else begin
            w_value = w_signed;
        end
    end

    always_comb begin
        o_emit = !w_cont || w_overflow || i_last;
        priority if (w_overflow) begin
            o_res = '{value: '0, byte_count: MAX_BYTES, status: ST_OVERFLOW};
        end else if (w_cont) begin
            o_res = '{value: '0, byte_count: '0, status: ST_TRUNC};
        end else begin
            o_res = '{value: w_value, byte_count: w_count, status: ST_OK};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc        <= '0;
            r_bit_shift  <= '0;
            r_bytes_seen <= '0;
        end else if (i_take) begin
            if (o_emit) begin
                r_acc        <= '0;
                r_bit_shift  <= '0;
                r_bytes_seen <= '0;
            end else begin
                r_acc        <= w_acc;
                r_bit_shift  <= r_bit_shift + GROUP_BITS;
                r_bytes_seen <= w_count;
            end
        end
    end

endmodule

### rtl/core/leb128_zigzag_varint_decoder.sv
// Top level of the LEB128 / zigzag varint decoder: input register, decode stage,
// result register and configuration port. Depends on lzv_pkg, lzv_cfg and lzv_dec.
//
//  Channel   Port group          Word contents
//  --------  ------------------  ------------------------------------------------
//  in        s_axis_*            tdata[7:0] data_byte; tlast last_in_buffer
//  out       m_axis_*            tdata[63:0] value, [67:64] byte_count; tuser status
//  config    psel/penable/...    register 0 at byte address 0: decode_mode[1:0]
//
// The block takes one byte per cycle unless a stalled output holds it back: a byte
// is first held in the input register and, if it ends a value, its result is then
// registered in the result register, which drives the output word.
// Reset is synchronous and active low; it clears the accumulator, the valid flags
// and sets decode_mode to 1. A stalled output only holds back the input register
// when the byte waiting there would produce a result; continuation bytes keep
// flowing into the accumulator while a finished result waits to be taken.
module leb128_zigzag_varint_decoder
    import lzv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input stream; tdata bits from the lowest: data_byte[7:0].
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,
    input  logic              s_axis_tlast,
    // Result stream; tdata bits from the lowest: value[63:0], byte_count[67:64], zero pad.
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [71:0]       m_axis_tdata,
    // tuser bits from the lowest: status[1:0].
    output logic [1:0]        m_axis_tuser,
    // Configuration port.
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    t_result           r_out_res;

    logic [MODE_W-1:0] w_mode;
    logic              w_emit;
    t_result           w_res;
    logic              w_out_free;
    logic              w_take;

    lzv_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_mode  (w_mode)
    );

    lzv_dec u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .i_mode  (w_mode),
        .o_emit  (w_emit),
        .o_res   (w_res)
    );

    // The result register is free when empty or being drained this cycle.
    assign w_out_free    = !r_out_valid || m_axis_tready;
    // A byte leaves the input register unless its result has nowhere to go.
    assign w_take        = r_in_valid && (!w_emit || w_out_free);
    assign s_axis_tready = !r_in_valid || w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_emit) begin
            r_out_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_res.byte_count, r_out_res.value};
    assign m_axis_tuser  = r_out_res.status;

endmodule

### rtl/core/lzv_checker.sv
// Port-level checker for the varint decoder, bound to the top level.
// Depends on lzv_pkg.
module lzv_checker
    import lzv_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [71:0]       m_axis_tdata,
    input  logic [1:0]        m_axis_tuser
);

    // An error result carries a zero value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_OK) |-> (m_axis_tdata[63:0] == '0))
        else $error("error result with nonzero value");

    // Byte count agrees with the status code.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ((m_axis_tuser == ST_OK) && (m_axis_tdata[67:64] != 4'd0)
                && (m_axis_tdata[67:64] <= MAX_BYTES)) ||
            ((m_axis_tuser == ST_TRUNC) && (m_axis_tdata[67:64] == 4'd0)) ||
            ((m_axis_tuser == ST_OVERFLOW) && (m_axis_tdata[67:64] == MAX_BYTES)))
        else $error("byte count does not match status");

    // Just after reset, no result appears unless a byte was accepted after reset.
    a_no_spurious: assert property (@(posedge i_clk)
        !i_rst_n ##1 !(s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
        else $error("result without input after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind leb128_zigzag_varint_decoder lzv_checker u_lzv_checker (.*);

### sim/leb128_zigzag_varint_decoder_tb.sv
// Self-checking testbench for the LEB128 / zigzag varint decoder: byte stream in,
// decoded values out, decode mode set over the APB-style port. Depends on lzv_pkg
// and leb128_zigzag_varint_decoder only.
module leb128_zigzag_varint_decoder_tb
    import lzv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Decode mode codes as they are written to the mode register.
    localparam logic [MODE_W-1:0] MODE_SIGNED      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SIGNED_ZZ   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNSIGNED_ZZ = 2'd2;
    // Mode 3 behaves as the unsigned zigzag form, since only bit 1 picks that path.
    localparam logic [MODE_W-1:0] MODE_ALIAS       = 2'd3;

    localparam int unsigned CYCLE_LIMIT   = 100000;
    // Wait after the last expected word, with margin for a byte still in flight.
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned PHASE_BYTES   = 250;
    localparam int unsigned NUM_PHASES    = 6;

    // One row of the directed stream. Rows marked as typed carry their own expected
    // result; all other rows are checked against the predictor.
    typedef struct packed {
        logic [7:0]         data_byte;
        logic               last;
        logic               typed;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] byte_count;
        t_status            status;
    } t_dir_row;

    localparam int unsigned NUM_DIR_ROWS = 24;
    localparam t_dir_row DIRECTED_ROWS [NUM_DIR_ROWS] = '{
        // A single zero byte decodes to zero in every mode.
        '{8'h00, 1'b0, 1'b1, 64'd0, 4'd1, ST_OK},
        // One byte with the sign bit set: sign extension, then zigzag.
        '{8'h7f, 1'b0, 1'b0, 64'd0, 4'd0, ST_OK},
        // A continuation byte that is also the last byte in the buffer.
        '{8'h80, 1'b1, 1'b1, 64'd0, 4'd0, ST_TRUNC},
        // Ten continuation bytes; the tenth also ends the buffer, and overflow wins.
        '{8'h80, 1'b0, 1'b0, 64'd0, 4'd0, ST_OK},
        '{8'h80, 1'b0, 1'b0, 64'd0, 4'd0, ST_OK},
        '{8'h80, 1'b0, 1'b0, 64'd0, 4'd0, ST_OK},
        '{8'h80, 1'b0, 1'b0, 64'd0, 4'd0, ST_OK},
        '{8'h80, 1'b0, 1'b0, 64'd0, 4'd0, ST_OK},
        '{8'h80, 1'b0, 1'b0, 64'd0, 4'd0, ST_OK},
        '{8'h80, 1'b0, 1'b0, 64'd0, 4'd0, ST_OK},
        '{8'h80, 1'b0, 1'b0, 64'd0, 4'd0, ST_OK},
        '{8'h80, 1'b0, 1'b0, 64'd0, 4'd0, ST_OK},
        '{8'hff, 1'b1, 1'b1, 64'd0, 4'd10, ST_OVERFLOW},
        // The byte right after an overflow starts a fresh value.
        '{8'h41, 1'b0, 1'b0, 64'd0, 4'd0, ST_OK},
        // A full ten-byte value: group bits past bit 63 drop, no sign extension.
        '{8'hff, 1'b0, 1'b0, 64'd0, 4'd0, ST_OK},
        '{8'hff, 1'b0, 1'b0, 64'd0, 4'd0, ST_OK},
        '{8'hff, 1'b0, 1'b0, 64'd0, 4'd0, ST_OK},
        '{8'hff, 1'b0, 1'b0, 64'd0, 4'd0, ST_OK},
        '{8'hff, 1'b0, 1'b0, 64'd0, 4'd0, ST_OK},
        '{8'hff, 1'b0, 1'b0, 64'd0, 4'd0, ST_OK},
        '{8'hff, 1'b0, 1'b0, 64'd0, 4'd0, ST_OK},
        '{8'hff, 1'b0, 1'b0, 64'd0, 4'd0, ST_OK},
        '{8'hff, 1'b0, 1'b0, 64'd0, 4'd0, ST_OK},
        '{8'h7f, 1'b0, 1'b0, 64'd0, 4'd0, ST_OK}
    };

    // Per phase: the mode written before it, and how often each side idles, in percent.
    // Phase 0 runs on the mode left by reset. The phases cover no idling, an idle
    // sender, a stalling receiver and both sides idling at once.
    localparam logic [MODE_W-1:0] PHASE_MODE [NUM_PHASES] =
        '{MODE_RESET, MODE_SIGNED, MODE_UNSIGNED_ZZ, MODE_ALIAS, MODE_UNSIGNED_ZZ, MODE_SIGNED_ZZ};
    localparam int unsigned PHASE_SEND_IDLE [NUM_PHASES] = '{0, 77, 0, 21, 21, 0};
    localparam int unsigned PHASE_RECV_STALL [NUM_PHASES] = '{0, 0, 77, 21, 21, 0};

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [71:0]       m_axis_tdata;
    logic [1:0]        m_axis_tuser;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Predictor state: the decode mode and the partly gathered value.
    logic [MODE_W-1:0]  mode_q = MODE_RESET;
    logic [VALUE_W-1:0] value_acc = '0;
    logic [6:0]         acc_shift = '0;
    logic [COUNT_W-1:0] bytes_taken = '0;

    t_result     pending_results [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    leb128_zigzag_varint_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 4 ns clock period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs or loses a word.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver back-pressure, redrawn every cycle on the falling edge.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Folds one input byte into the predicted decoder state. When the byte ends a
    // value, runs off the buffer end or overflows, it returns the result and clears
    // the gathered value.
    task automatic decode_byte(input logic [7:0] data_byte, input logic last,
                               output bit has_res, output t_result res);
        logic [COUNT_W-1:0] count;
        logic [6:0]         next_shift;
        logic [VALUE_W-1:0] v;
        bit                 apply_zigzag;
        has_res = 1'b1;
        res = '0;
        // Groups that would land at bit 64 or above are simply lost.
        if (acc_shift < 7'd64)
            value_acc = value_acc | ({57'd0, data_byte[6:0]} << acc_shift);
        count = bytes_taken + 4'd1;
        next_shift = 7'(count) * 7'd7;
        if (data_byte[7]) begin
            // Overflow is checked first, so it wins over truncation on the tenth byte.
            if (count >= MAX_BYTES) begin
                res.byte_count = MAX_BYTES;
                res.status = ST_OVERFLOW;
            end else if (last) begin
                res.status = ST_TRUNC;
            end else begin
                has_res = 1'b0;
                bytes_taken = count;
                acc_shift = next_shift;
            end
        end else begin
            v = value_acc;
            apply_zigzag = mode_q[MODE_UNSIGNED_BIT];
            if (!mode_q[MODE_UNSIGNED_BIT]) begin
                // Signed forms: bit 6 of the final byte fills every bit above the
                // gathered groups, unless the groups already reach bit 63.
                if (next_shift < 7'd64 && data_byte[6])
                    v = v | ~((64'd1 << next_shift) - 64'd1);
                apply_zigzag = mode_q[MODE_ZIGZAG_BIT];
            end
            if (apply_zigzag)
                v = (v >> 1) ^ {VALUE_W{v[0]}};
            res.value = v;
            res.byte_count = count;
            res.status = ST_OK;
        end
        if (has_res) begin
            value_acc = '0;
            acc_shift = '0;
            bytes_taken = '0;
        end
    endtask

    // Offers one byte, with random idle cycles first, and waits for the handshake.
    // Entered and left on a falling edge. On acceptance the expected result, if any,
    // is queued; a typed row supplies its own expectation instead of the predictor's.
    task automatic send_byte(input logic [7:0] data_byte, input logic last,
                             input bit use_typed, input t_result typed_res);
        bit      has_res;
        t_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data_byte;
        s_axis_tlast <= last;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        decode_byte(data_byte, last, has_res, res);
        if (use_typed)
            pending_results.push_back(typed_res);
        else if (has_res)
            pending_results.push_back(res);
        @(negedge i_clk);
    endtask

    // Stops sending and waits until every expected word has come out, then waits out
    // SETTLE_CYCLES so that no continuation byte is still inside the block.
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Writes the decode mode with a setup phase and an access phase.
    task automatic write_mode(input logic [MODE_W-1:0] mode);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {REG_DECODE_MODE, 2'b00};
        pwdata <= APB_DW'(mode);
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        mode_q = mode;
    endtask

    // Random part of a phase. Most of the stream is well-formed values of random
    // length and content; the rest is loose bytes, values cut off by the buffer end
    // and runs of continuation bytes long enough to overflow. Halfway through, the
    // sender holds off until everything expected so far has arrived.
    task automatic run_random(input int unsigned n_bytes);
        int unsigned sent;
        int unsigned len;
        int unsigned pick;
        bit          paused;
        logic [7:0]  data_byte;
        logic        last;
        sent = 0;
        paused = 1'b0;
        while (sent < n_bytes) begin
            if (!paused && sent >= n_bytes / 2) begin
                settle_idle();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 10) begin
                data_byte = 8'($urandom_range(255));
                last = ($urandom_range(7) == 0);
                send_byte(data_byte, last, 1'b0, '0);
                sent++;
            end else begin
                if (pick < 16)
                    len = $urandom_range(14, 10);
                else if (pick < 55)
                    len = $urandom_range(2, 1);
                else if (pick < 85)
                    len = $urandom_range(5, 3);
                else
                    len = $urandom_range(9, 6);
                for (int unsigned k = 1; k <= len; k++) begin
                    data_byte = 8'($urandom_range(255));
                    data_byte[7] = (k < len);
                    // Now and then the buffer ends on a final byte, or mid-value.
                    if (k == len)
                        last = ($urandom_range(5) == 0);
                    else
                        last = ($urandom_range(29) == 0);
                    send_byte(data_byte, last, 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    // Output monitor: each accepted word is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        t_result seen;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.value = m_axis_tdata[63:0];
            seen.byte_count = m_axis_tdata[67:64];
            seen.status = t_status'(m_axis_tuser);
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word: value %h byte_count %0d status %0d",
                         $time, seen.value, seen.byte_count, seen.status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (seen.value !== want.value) begin
                    $display("%0t: value mismatch: expected %h, actual %h",
                             $time, want.value, seen.value);
                    mismatch_count++;
                end
                if (seen.byte_count !== want.byte_count) begin
                    $display("%0t: byte_count mismatch: expected %0d, actual %0d",
                             $time, want.byte_count, seen.byte_count);
                    mismatch_count++;
                end
                if (seen.status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, seen.status);
                    mismatch_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed rows on the reset mode, then one random phase
    // per mode and idling pattern, each mode change made with the block drained.
    initial begin
        t_result typed_res;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int unsigned p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                settle_idle();
                write_mode(PHASE_MODE[p]);
            end
            send_idle_pct = PHASE_SEND_IDLE[p];
            recv_stall_pct = PHASE_RECV_STALL[p];
            if (p == 0) begin
                for (int unsigned r = 0; r < NUM_DIR_ROWS; r++) begin
                    typed_res.value = DIRECTED_ROWS[r].value;
                    typed_res.byte_count = DIRECTED_ROWS[r].byte_count;
                    typed_res.status = DIRECTED_ROWS[r].status;
                    send_byte(DIRECTED_ROWS[r].data_byte, DIRECTED_ROWS[r].last,
                              DIRECTED_ROWS[r].typed, typed_res);
                end
            end
            run_random(PHASE_BYTES);
        end
        settle_idle();
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
rtl/core/lzv_pkg.sv
rtl/core/lzv_cfg.sv
rtl/core/lzv_dec.sv
rtl/core/leb128_zigzag_varint_decoder.sv
rtl/core/lzv_checker.sv
sim/leb128_zigzag_varint_decoder_tb.sv
